/* sv/tgcd_pkg.sv */
package tgcd_pkg;

   // Cursor width; coordinates wrap at this many bits and are sign-extended on output.
   localparam int COORD_BITS = 32;
   localparam int WORD_BITS = 32;
   localparam int COUNT_BITS = 29;
   localparam int MAX_RESULTS = 3;

   localparam logic [2:0] CMD_MOVE_TO = 3'd1;
   localparam logic [2:0] CMD_LINE_TO = 3'd2;
   localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_POINT = 2'd1,
      KIND_LINE = 2'd2,
      KIND_POLYGON = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_CMD = 2'd0,
      PHASE_X = 2'd1,
      PHASE_Y = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      FILL_EMPTY = 2'd0,
      FILL_ONE = 2'd1,
      FILL_TWO = 2'd2,
      FILL_OPEN = 2'd3
   } fill_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   // Results caused by one input word, in emission order from entry 0.
   typedef struct packed {
      logic [1:0] count;
      point_type [MAX_RESULTS-1:0] pts;
      logic [MAX_RESULTS-1:0] start;
   } burst_type;

   function automatic logic [31:0] unzig(input logic [WORD_BITS-1:0] w);
      return {1'b0, w[WORD_BITS-1:1]} ^ {WORD_BITS{w[0]}};
   endfunction

   function automatic logic signed [31:0] wrap_coord(input logic [31:0] s);
      logic signed [COORD_BITS-1:0] t;
      t = s[COORD_BITS-1:0];
      return 32'(t);
   endfunction

endpackage

/* sv/tgcd_req_if.sv */
interface tgcd_req_if;
   logic valid;
   logic ready;
   logic [tgcd_pkg::WORD_BITS-1:0] word;
   logic [1:0] geometry_kind;
   logic final_word;

   modport source (output valid, output word, output geometry_kind, output final_word,
                   input ready);
   modport sink (input valid, input word, input geometry_kind, input final_word,
                 output ready);
endinterface

/* sv/tgcd_rsp_if.sv */
interface tgcd_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] vertex_x;
   logic signed [31:0] vertex_y;
   logic ring_start;
   logic run_end;

   modport source (output valid, output vertex_x, output vertex_y, output ring_start,
                   output run_end, input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input ring_start,
                 input run_end, output ready);
endinterface

/* sv/tile_geometry_command_decoder_top.sv */
// Flow: a word waits in the input register until the burst register can take its
// results; its vertices leave from the burst register starting the cycle after it is decoded.
// Throughput: one word per cycle while each word yields at most one vertex and the receiver
// is ready; a word yielding more holds the decoder while they leave by the single output port.
// Reset (synchronous, active high) empties both registers and returns the decoder to
// waiting for a command word with the cursor at the origin and no open ring.
module tile_geometry_command_decoder_top (
   input logic clock,
   input logic reset,
   tgcd_req_if.sink req_chan,
   tgcd_rsp_if.source rsp_chan
);

   // Input register: holds one accepted word until the burst register can take its results.
   logic in_valid_ff, in_valid_in;
   logic [tgcd_pkg::WORD_BITS-1:0] in_word_ff;
   tgcd_pkg::kind_type in_kind_ff;
   logic in_fin_ff;

   // Burst register: the vertices of one decoded word, drained one per handshake.
   tgcd_pkg::burst_type burst_ff;
   tgcd_pkg::burst_type burst;
   logic [1:0] left_ff, left_in;
   logic [1:0] idx_ff, idx_in;

   logic burst_free;
   logic consume;
   logic req_take;
   logic rsp_take;

   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   // The burst register is free when empty or when its last vertex is leaving this cycle.
   assign burst_free = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_chan.ready);
   assign consume = in_valid_ff && burst_free;
   assign req_chan.ready = !in_valid_ff || consume;
   assign req_take = req_chan.valid && req_chan.ready;

   tgcd_core u_core (
      .clock(clock),
      .reset(reset),
      .advance(consume),
      .word(in_word_ff),
      .kind(in_kind_ff),
      .fin(in_fin_ff),
      .burst(burst)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      left_in = left_ff;
      idx_in = idx_ff;
      if (consume) begin
         left_in = burst.count;
         idx_in = 2'd0;
      end else if (rsp_take) begin
         left_in = left_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         left_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         left_ff <= left_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_chan.word;
         in_kind_ff <= tgcd_pkg::kind_type'(req_chan.geometry_kind);
         in_fin_ff <= req_chan.final_word;
      end
      if (consume) begin
         burst_ff <= burst;
      end
   end

   assign rsp_chan.valid = (left_ff != 2'd0);
   assign rsp_chan.vertex_x = burst_ff.pts[idx_ff].x;
   assign rsp_chan.vertex_y = burst_ff.pts[idx_ff].y;
   assign rsp_chan.ring_start = burst_ff.start[idx_ff];
   // The last vertex of a word is the one that empties the burst register.
   assign rsp_chan.run_end = (left_ff == 2'd1);

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      consume && left_ff != 2'd0 |-> left_ff == 2'd1 && rsp_take)
      else $error("burst register overwritten before it drained");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (32'(idx_ff) + 32'(left_ff)) <= tgcd_pkg::MAX_RESULTS)
      else $error("burst read index past the stored vertices");

   a_word_drains: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(in_word_ff))
      else $error("pending word lost before decode");

endmodule

/* sv/tgcd_core.sv */
module tgcd_core (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [tgcd_pkg::WORD_BITS-1:0] word,
   input  tgcd_pkg::kind_type kind,
   input  logic fin,
   output tgcd_pkg::burst_type burst
);

   tgcd_pkg::phase_type phase_ff, phase_in;
   tgcd_pkg::fill_type fill_ff, fill_in;
   logic [tgcd_pkg::COUNT_BITS-1:0] pairs_left_ff, pairs_left_in;
   logic moving_ff, moving_in;
   logic signed [31:0] cursor_x_ff, cursor_x_in;
   logic signed [31:0] cursor_y_ff, cursor_y_in;
   logic [tgcd_pkg::WORD_BITS-1:0] held_dx_ff, held_dx_in;
   tgcd_pkg::point_type first_ff, first_in;
   tgcd_pkg::point_type pend0_ff, pend0_in;
   tgcd_pkg::point_type pend1_ff, pend1_in;

   tgcd_pkg::point_type new_pt;
   tgcd_pkg::point_type add_pt;
   logic add_en;
   logic [2:0] cmd;
   logic ring_kind;

   assign cmd = word[2:0];
   assign ring_kind = (kind == tgcd_pkg::KIND_LINE) || (kind == tgcd_pkg::KIND_POLYGON);
   assign new_pt.x = tgcd_pkg::wrap_coord(cursor_x_ff + tgcd_pkg::unzig(held_dx_ff));
   assign new_pt.y = tgcd_pkg::wrap_coord(cursor_y_ff + tgcd_pkg::unzig(word));

   always_comb begin
      phase_in = phase_ff;
      fill_in = fill_ff;
      pairs_left_in = pairs_left_ff;
      moving_in = moving_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      held_dx_in = held_dx_ff;
      first_in = first_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      add_en = 1'b0;
      add_pt = new_pt;
      burst = '0;

      unique case (phase_ff)
         tgcd_pkg::PHASE_X: begin
            held_dx_in = word;
            phase_in = tgcd_pkg::PHASE_Y;
         end
         tgcd_pkg::PHASE_Y: begin
            cursor_x_in = new_pt.x;
            cursor_y_in = new_pt.y;
            pairs_left_in = pairs_left_ff - 1'b1;
            phase_in = (pairs_left_in != '0) ? tgcd_pkg::PHASE_X : tgcd_pkg::PHASE_CMD;
            if (kind == tgcd_pkg::KIND_POINT) begin
               if (moving_ff) begin
                  burst.count = 2'd1;
                  burst.pts[0] = new_pt;
                  burst.start[0] = 1'b1;
               end
            end else begin
               add_en = ring_kind;
            end
         end
         default: begin
            phase_in = tgcd_pkg::PHASE_CMD;
            unique case (cmd)
               tgcd_pkg::CMD_MOVE_TO: begin
                  fill_in = tgcd_pkg::FILL_EMPTY;
                  moving_in = 1'b1;
                  pairs_left_in = word[tgcd_pkg::WORD_BITS-1:3];
                  phase_in = (pairs_left_in != '0) ? tgcd_pkg::PHASE_X : tgcd_pkg::PHASE_CMD;
               end
               tgcd_pkg::CMD_LINE_TO: begin
                  moving_in = 1'b0;
                  pairs_left_in = word[tgcd_pkg::WORD_BITS-1:3];
                  phase_in = (pairs_left_in != '0) ? tgcd_pkg::PHASE_X : tgcd_pkg::PHASE_CMD;
               end
               tgcd_pkg::CMD_CLOSE_PATH: begin
                  add_en = ring_kind && (fill_ff != tgcd_pkg::FILL_EMPTY);
                  add_pt = first_ff;
               end
               default: begin
               end
            endcase
         end
      endcase

      // A point joins the open ring; the held points go out once the ring is long enough.
      if (add_en) begin
         unique case (fill_ff)
            tgcd_pkg::FILL_EMPTY: begin
               first_in = add_pt;
               pend0_in = add_pt;
               fill_in = tgcd_pkg::FILL_ONE;
            end
            tgcd_pkg::FILL_ONE: begin
               if (kind == tgcd_pkg::KIND_LINE) begin
                  burst.count = 2'd2;
                  burst.pts[0] = pend0_ff;
                  burst.start[0] = 1'b1;
                  burst.pts[1] = add_pt;
                  fill_in = tgcd_pkg::FILL_OPEN;
               end else begin
                  pend1_in = add_pt;
                  fill_in = tgcd_pkg::FILL_TWO;
               end
            end
            tgcd_pkg::FILL_TWO: begin
               burst.count = 2'd3;
               burst.pts[0] = pend0_ff;
               burst.start[0] = 1'b1;
               burst.pts[1] = pend1_ff;
               burst.pts[2] = add_pt;
               fill_in = tgcd_pkg::FILL_OPEN;
            end
            default: begin
               burst.count = 2'd1;
               burst.pts[0] = add_pt;
            end
         endcase
      end

      if (fin) begin
         phase_in = tgcd_pkg::PHASE_CMD;
         fill_in = tgcd_pkg::FILL_EMPTY;
         pairs_left_in = '0;
         moving_in = 1'b0;
         cursor_x_in = '0;
         cursor_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tgcd_pkg::PHASE_CMD;
         fill_ff <= tgcd_pkg::FILL_EMPTY;
         pairs_left_ff <= '0;
         moving_ff <= 1'b0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         fill_ff <= fill_in;
         pairs_left_ff <= pairs_left_in;
         moving_ff <= moving_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

   // Held delta and ring points are always written before they are read.
   always_ff @(posedge clock) begin
      if (advance) begin
         held_dx_ff <= held_dx_in;
         first_ff <= first_in;
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
      end
   end

   a_x_has_pairs: assert property (@(posedge clock) disable iff (reset)
      phase_ff == tgcd_pkg::PHASE_X |-> pairs_left_ff != '0)
      else $error("parameter phase entered with no pairs left");

   a_burst_starts_ring: assert property (@(posedge clock) disable iff (reset)
      advance && burst.count > 2'd1 |-> burst.start[0])
      else $error("multi-vertex burst does not open a ring");

   a_three_from_two: assert property (@(posedge clock) disable iff (reset)
      advance && burst.count == 2'd3 |-> fill_ff == tgcd_pkg::FILL_TWO)
      else $error("three vertices emitted without two held points");

endmodule

/* dv/testbench.sv */
module testbench;

   // Minimum number of words sent in the random part, on top of the directed opening.
   localparam int RANDOM_WORDS = 410;
   // The last words go out with neither side idling.
   localparam int QUIET_WORDS = 80;
   // Word index at which the receiver starts its long hold-off.
   localparam int HOLD_OFF_AT = 150;
   localparam int HOLD_OFF_CYCLES = 120;
   // Cycles without any handshake before the run is declared hung. The longest
   // legitimate gap is the hold-off plus a few bursts of idling.
   localparam int WATCHDOG_LIMIT = 1000;
   // Margin after the drain; it catches any stray vertex.
   localparam int DRAIN_CYCLES = 16;
   localparam int SHIFT = 32 - tgcd_pkg::COORD_BITS;

   // One word as it is offered on the request channel.
   typedef struct {
      logic [31:0] word;
      tgcd_pkg::kind_type kind;
      logic ends_geometry;
   } word_item_type;

   // One vertex as it is expected on the response channel.
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic ring_start;
      logic run_end;
   } vertex_rec_type;

   // Mirrors the decoder: it walks the command stream word by word, keeps the
   // cursor and the open ring, and queues the vertices each word should produce.
   class vertex_decoder_model_type;
      vertex_rec_type expected_vertices[$];
      vertex_rec_type burst[$];
      int errors;

      tgcd_pkg::phase_type phase;
      logic [tgcd_pkg::COUNT_BITS-1:0] pairs_left;
      logic moving;
      logic [31:0] cursor_x;
      logic [31:0] cursor_y;
      logic [31:0] held_dx;
      tgcd_pkg::point_type ring_first;
      tgcd_pkg::point_type held_pts [2];
      tgcd_pkg::fill_type fill;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase = tgcd_pkg::PHASE_CMD;
         pairs_left = '0;
         moving = 1'b0;
         cursor_x = '0;
         cursor_y = '0;
         held_dx = '0;
         ring_first = '0;
         held_pts[0] = '0;
         held_pts[1] = '0;
         fill = tgcd_pkg::FILL_EMPTY;
      endfunction

      // Zigzag decoding maps 0,1,2,3,... onto 0,-1,1,-2,...
      function logic [31:0] zigzag_delta(logic [31:0] w);
         return (w >> 1) ^ {32{w[0]}};
      endfunction

      // Keeps the low COORD_BITS bits and sign-extends them back to 32.
      function logic [31:0] wrap(logic [31:0] v);
         logic [31:0] t;
         t = v << SHIFT;
         return $signed(t) >>> SHIFT;
      endfunction

      function void emit(tgcd_pkg::point_type p, logic first);
         vertex_rec_type v;
         v.x = p.x;
         v.y = p.y;
         v.ring_start = first;
         v.run_end = 1'b0;
         burst.push_back(v);
      endfunction

      // Points of a line or polygon ring are held back until the ring is long
      // enough to survive; then the held points go out ahead of the new one.
      function void add_to_ring(tgcd_pkg::kind_type kind, tgcd_pkg::point_type p);
         case (fill)
            tgcd_pkg::FILL_EMPTY: begin
               ring_first = p;
               held_pts[0] = p;
               fill = tgcd_pkg::FILL_ONE;
            end
            tgcd_pkg::FILL_ONE: begin
               if (kind == tgcd_pkg::KIND_LINE) begin
                  emit(held_pts[0], 1'b1);
                  emit(p, 1'b0);
                  fill = tgcd_pkg::FILL_OPEN;
               end else begin
                  held_pts[1] = p;
                  fill = tgcd_pkg::FILL_TWO;
               end
            end
            tgcd_pkg::FILL_TWO: begin
               emit(held_pts[0], 1'b1);
               emit(held_pts[1], 1'b0);
               emit(p, 1'b0);
               fill = tgcd_pkg::FILL_OPEN;
            end
            default: begin
               emit(p, 1'b0);
            end
         endcase
      endfunction

      function void decode_word(logic [31:0] w, tgcd_pkg::kind_type kind,
                                logic ends_geometry);
         tgcd_pkg::point_type p;
         logic [2:0] cmd;
         logic [tgcd_pkg::COUNT_BITS-1:0] cnt;
         logic ring_kind;
         burst.delete();
         ring_kind = (kind == tgcd_pkg::KIND_LINE) || (kind == tgcd_pkg::KIND_POLYGON);
         case (phase)
            tgcd_pkg::PHASE_X: begin
               held_dx = w;
               phase = tgcd_pkg::PHASE_Y;
            end
            tgcd_pkg::PHASE_Y: begin
               cursor_x = wrap(cursor_x + zigzag_delta(held_dx));
               cursor_y = wrap(cursor_y + zigzag_delta(w));
               pairs_left = pairs_left - 1'b1;
               phase = (pairs_left != 0) ? tgcd_pkg::PHASE_X : tgcd_pkg::PHASE_CMD;
               p.x = cursor_x;
               p.y = cursor_y;
               if (kind == tgcd_pkg::KIND_POINT) begin
                  if (moving) emit(p, 1'b1);
               end else if (ring_kind) begin
                  add_to_ring(kind, p);
               end
            end
            default: begin
               cmd = w[2:0];
               cnt = w[31:3];
               phase = tgcd_pkg::PHASE_CMD;
               if (cmd == tgcd_pkg::CMD_MOVE_TO) begin
                  fill = tgcd_pkg::FILL_EMPTY;
                  moving = 1'b1;
                  pairs_left = cnt;
                  phase = (cnt != 0) ? tgcd_pkg::PHASE_X : tgcd_pkg::PHASE_CMD;
               end else if (cmd == tgcd_pkg::CMD_LINE_TO) begin
                  moving = 1'b0;
                  pairs_left = cnt;
                  phase = (cnt != 0) ? tgcd_pkg::PHASE_X : tgcd_pkg::PHASE_CMD;
               end else if (cmd == tgcd_pkg::CMD_CLOSE_PATH) begin
                  if (ring_kind && fill != tgcd_pkg::FILL_EMPTY) add_to_ring(kind, ring_first);
               end
            end
         endcase
         if (burst.size() > 0) burst[burst.size()-1].run_end = 1'b1;
         foreach (burst[i]) expected_vertices.push_back(burst[i]);
         if (ends_geometry) clear_state();
      endfunction

      function void compare_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                   logic ring_start, logic run_end);
         vertex_rec_type e;
         if (expected_vertices.size() == 0) begin
            $error("vertex x=%0d y=%0d arrived with none expected", x, y);
            errors++;
            return;
         end
         e = expected_vertices.pop_front();
         if (x !== e.x) begin
            $error("vertex_x: expected %0d, got %0d", e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $error("vertex_y: expected %0d, got %0d", e.y, y);
            errors++;
         end
         if (ring_start !== e.ring_start) begin
            $error("ring_start: expected %0b, got %0b", e.ring_start, ring_start);
            errors++;
         end
         if (run_end !== e.run_end) begin
            $error("run_end: expected %0b, got %0b", e.run_end, run_end);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_vertices.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   tgcd_req_if req_bus();
   tgcd_rsp_if rsp_bus();

   vertex_decoder_model_type decoder_model = new();
   word_item_type stimulus[$];
   bit quiet = 1'b0;
   int words_sent = 0;
   bit hold_off_done = 1'b0;
   int stall_left = 0;
   int stalled_cycles;

   tile_geometry_command_decoder_top DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [31:0] command_word(int cnt, logic [2:0] cmd);
      logic [tgcd_pkg::COUNT_BITS-1:0] c;
      c = cnt[tgcd_pkg::COUNT_BITS-1:0];
      return {c, cmd};
   endfunction

   // Any of the five codes the decoder does not act on.
   function automatic logic [2:0] unused_command();
      logic [2:0] c;
      do
         c = 3'($urandom_range(0, 7));
      while (c == tgcd_pkg::CMD_MOVE_TO || c == tgcd_pkg::CMD_LINE_TO ||
             c == tgcd_pkg::CMD_CLOSE_PATH);
      return c;
   endfunction

   // Mostly short hops around the cursor, now and then a full-range jump that
   // makes the cursor wrap.
   function automatic logic [31:0] random_delta();
      case ($urandom_range(0, 15))
         0: return $urandom();
         1: return 32'hFFFF_FFFF;
         2: return 32'hFFFF_FFFE;
         default: return $urandom_range(0, 64);
      endcase
   endfunction

   task automatic queue_word(logic [31:0] w, tgcd_pkg::kind_type kind, logic ends_geometry);
      stimulus.push_back('{w, kind, ends_geometry});
   endtask

   // A command word followed, for MoveTo and LineTo, by its coordinate pairs.
   task automatic push_command(ref word_item_type geo[$], input tgcd_pkg::kind_type kind,
                               input logic [2:0] cmd, input int cnt);
      geo.push_back('{command_word(cnt, cmd), kind, 1'b0});
      if (cmd == tgcd_pkg::CMD_MOVE_TO || cmd == tgcd_pkg::CMD_LINE_TO) begin
         repeat (cnt) begin
            geo.push_back('{random_delta(), kind, 1'b0});
            geo.push_back('{random_delta(), kind, 1'b0});
         end
      end
   endtask

   task automatic queue_directed();
      // Polygon: the first point sits at the extremes of both axes, then a
      // MoveTo with no pairs drops that one-point ring, a ClosePath finds no
      // ring, and a full triangle follows whose cursor wraps in x and which a
      // ClosePath finishes by repeating its first point.
      queue_word(command_word(1, tgcd_pkg::CMD_MOVE_TO), tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'hFFFF_FFFF, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'hFFFF_FFFE, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(command_word(0, tgcd_pkg::CMD_MOVE_TO), tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(command_word(1, tgcd_pkg::CMD_CLOSE_PATH), tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(command_word(1, tgcd_pkg::CMD_MOVE_TO), tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd3, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd3, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(command_word(2, tgcd_pkg::CMD_LINE_TO), tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'hFFFF_FFFF, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd0, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd4, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd4, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(command_word(1, tgcd_pkg::CMD_CLOSE_PATH), tgcd_pkg::KIND_POLYGON, 1'b1);
      // Point geometry: every MoveTo point is a ring of its own; LineTo moves
      // the cursor silently, ClosePath and an unknown code with the largest
      // count do nothing.
      queue_word(command_word(2, tgcd_pkg::CMD_MOVE_TO), tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(32'd1, tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(32'd1, tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(32'd2, tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(32'd2, tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(command_word(1, tgcd_pkg::CMD_LINE_TO), tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(32'd5, tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(32'd5, tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(command_word(1, tgcd_pkg::CMD_CLOSE_PATH), tgcd_pkg::KIND_POINT, 1'b0);
      queue_word(command_word('1, unused_command()), tgcd_pkg::KIND_POINT, 1'b1);
      // A MoveTo with the largest count; two points are held as a polygon,
      // then the kind turns to line and the third point releases all three.
      // The geometry ends on an x word with no y.
      queue_word(command_word('1, tgcd_pkg::CMD_MOVE_TO), tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd2, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd2, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd4, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd4, tgcd_pkg::KIND_POLYGON, 1'b0);
      queue_word(32'd6, tgcd_pkg::KIND_LINE, 1'b0);
      queue_word(32'd6, tgcd_pkg::KIND_LINE, 1'b0);
      queue_word(32'd5, tgcd_pkg::KIND_LINE, 1'b1);
      // Unknown kind: a LineTo without pairs, then a point that moves the
      // cursor but produces no vertex.
      queue_word(command_word(0, tgcd_pkg::CMD_LINE_TO), tgcd_pkg::KIND_UNKNOWN, 1'b0);
      queue_word(command_word(1, tgcd_pkg::CMD_MOVE_TO), tgcd_pkg::KIND_UNKNOWN, 1'b0);
      queue_word(32'd3, tgcd_pkg::KIND_UNKNOWN, 1'b0);
      queue_word(32'd3, tgcd_pkg::KIND_UNKNOWN, 1'b1);
   endtask

   // Most geometries are well formed with random content. A few are pure
   // noise, some change kind midway and some are cut short, which can leave a
   // lone x word or a short ring behind at the end of the geometry.
   task automatic queue_random_geometry();
      word_item_type geo[$];
      tgcd_pkg::kind_type kind;
      int pick;
      int cmds;
      int cut;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 6))
            geo.push_back('{$urandom(), tgcd_pkg::kind_type'($urandom_range(0, 3)), 1'b0});
      end else begin
         case ($urandom_range(0, 9))
            0: kind = tgcd_pkg::KIND_UNKNOWN;
            1, 2: kind = tgcd_pkg::KIND_POINT;
            3, 4, 5: kind = tgcd_pkg::KIND_LINE;
            default: kind = tgcd_pkg::KIND_POLYGON;
         endcase
         cmds = $urandom_range(1, 5);
         for (int i = 0; i < cmds; i++) begin
            pick = $urandom_range(0, 19);
            if (i == 0 || pick < 6) begin
               if (kind == tgcd_pkg::KIND_POINT)
                  push_command(geo, kind, tgcd_pkg::CMD_MOVE_TO, $urandom_range(0, 3));
               else
                  push_command(geo, kind, tgcd_pkg::CMD_MOVE_TO, (pick == 1) ? 0 : 1);
            end else if (pick < 15) begin
               push_command(geo, kind, tgcd_pkg::CMD_LINE_TO, $urandom_range(0, 4));
            end else if (pick < 18) begin
               push_command(geo, kind, tgcd_pkg::CMD_CLOSE_PATH,
                            (pick == 15) ? $urandom_range(0, 9) : 1);
            end else begin
               push_command(geo, kind, unused_command(), $urandom_range(0, 9));
            end
         end
         if ($urandom_range(0, 9) == 0)
            geo[$urandom_range(0, geo.size() - 1)].kind =
               tgcd_pkg::kind_type'($urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, geo.size());
            while (geo.size() > cut) void'(geo.pop_back());
         end
      end
      geo[geo.size() - 1].ends_geometry = 1'b1;
      foreach (geo[i]) stimulus.push_back(geo[i]);
   endtask

   // Offers one word, possibly after a short idle burst, and returns at the
   // clock edge where it is taken. Valid is only lowered for a real gap, so it
   // stays high between back-to-back words.
   task automatic send_word(word_item_type item);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.word <= item.word;
      req_bus.geometry_kind <= item.kind;
      req_bus.final_word <= item.ends_geometry;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      decoder_model.decode_word(item.word, item.kind, item.ends_geometry);
   endtask

   // Receiver: random stall bursts, and once a long hold-off so that the
   // decoder backs up and has to stall the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_off_done && words_sent >= HOLD_OFF_AT) begin
         hold_off_done = 1'b1;
         stall_left = HOLD_OFF_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every vertex taken by the receiver is checked against the oldest one
   // still expected.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         decoder_model.compare_vertex(rsp_bus.vertex_x, rsp_bus.vertex_y,
                                      rsp_bus.ring_start, rsp_bus.run_end);
   end

   // Watchdog: counts cycles in which neither channel moves a word.
   initial begin
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("[tile_geometry_command_decoder_top] ERROR");
      $finish;
   end

   initial begin
      int directed_count;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.word <= '0;
      req_bus.geometry_kind <= '0;
      req_bus.final_word <= 1'b0;

      queue_directed();
      directed_count = stimulus.size();
      while (stimulus.size() < directed_count + RANDOM_WORDS) queue_random_geometry();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus[i]) begin
         quiet = (i >= stimulus.size() - QUIET_WORDS);
         words_sent = i;
         send_word(stimulus[i]);
      end
      req_bus.valid <= 1'b0;

      // Drain: every expected vertex must arrive, then a short margin shows
      // that nothing else follows.
      while (decoder_model.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (decoder_model.errors == 0) begin
         $display("[tile_geometry_command_decoder_top] OK");
      end else begin
         $display("[tile_geometry_command_decoder_top] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
sv/tgcd_pkg.sv
sv/tgcd_req_if.sv
sv/tgcd_rsp_if.sv
sv/tgcd_core.sv
sv/tile_geometry_command_decoder_top.sv
dv/testbench.sv
